// ===== rtl/core/qslerp_pkg.sv =====
// Shared types, constants and helpers for the quaternion slerp pipeline.
package qslerp_pkg;

   localparam int WB = 30;
   localparam int SQ_N = WB + 1;
   localparam int QB = 39;
   localparam int DIV_LAT = QB + 2;

   localparam logic [WB:0] ONE_W = (WB + 1)'(1) << WB;
   localparam logic signed [33:0] INV_GAIN = 34'sd652032874;
   localparam longint NP_LIM = (longint'(9999) << WB) / 10000;

   localparam logic [30:0] ATAN_TAB [32] = '{
      31'h3243F6A8, 31'h1DAC6705, 31'h0FADBAFC, 31'h07F56EA6, 31'h03FEAB76, 31'h01FFD55B,
      31'h00FFFAAA, 31'h007FFF55, 31'h003FFFEA, 31'h001FFFFD, 31'h000FFFFF, 31'h0007FFFF,
      31'h0003FFFF, 31'h0001FFFF, 31'h0000FFFF, 31'h00007FFF, 31'h00003FFF, 31'h00001FFF,
      31'h00000FFF, 31'h000007FF, 31'h000003FF, 31'h000001FF, 31'h000000FF, 31'h0000007F,
      31'h0000003F, 31'h0000001F, 31'h0000000F, 31'h00000007, 31'h00000003, 31'h00000001,
      31'h00000000, 31'h00000000
   };

   typedef enum logic [1:0] {
      SEL_MIX,
      SEL_SRC,
      SEL_DST
   } sel_type;

   typedef struct packed {
      logic signed [15:0] src_w;
      logic signed [15:0] src_x;
      logic signed [15:0] src_y;
      logic signed [15:0] src_z;
      logic signed [15:0] dst_w;
      logic signed [15:0] dst_x;
      logic signed [15:0] dst_y;
      logic signed [15:0] dst_z;
      logic signed [15:0] blend;
   } req_type;

   typedef struct packed {
      logic signed [15:0] res_w;
      logic signed [15:0] res_x;
      logic signed [15:0] res_y;
      logic signed [15:0] res_z;
   } rsp_type;

   typedef struct packed {
      logic [3:0][16:0] sp;
      logic [3:0][15:0] dq;
      logic [WB-1:0]    t30;
      logic [WB:0]      c30;
      sel_type          sel;
      logic             np;
   } side_type;

   function automatic logic [15:0] sat16(input logic signed [27:0] v);
      logic [15:0] r;
      if (v > 28'sd32767) begin
         r = 16'h7FFF;
      end else if (v < -28'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/quaternion_slerp_top.sv =====
// Quaternion slerp: dot product, root, CORDIC angle and sines, divide, mix.
// The path from accepted beat to rsp_valid is set mostly by the 31-step root,
// both CORDICs and the divider.
// Throughput: one beat per cycle; a held result stalls the whole pipeline.
// Reset: synchronous, active high, clears all valid bits; data is not reset.
module quaternion_slerp_top #(
   parameter int FRAC_BITS = 14,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  qslerp_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output qslerp_pkg::rsp_type rsp_data
);

   localparam int WB = qslerp_pkg::WB;
   localparam int CS = CORDIC_STAGES;
   localparam int SQ_N = qslerp_pkg::SQ_N;
   localparam int P_SN = 6 + SQ_N;
   localparam int P_OM = P_SN + CS;
   localparam int P_SIN = P_OM + 1 + CS;
   localparam int P_K = P_SIN + qslerp_pkg::DIV_LAT;
   localparam int P_OUT = P_K + 2;
   localparam int SIDE_N = P_K - 4;
   localparam int SN_N = P_SIN - P_SN;
   localparam longint HI_LIM = (longint'(9999) << FRAC_BITS) / 10000;
   localparam longint LO_LIM = ((longint'(1) << FRAC_BITS) + 9999) / 10000;
   localparam longint DOT_LIM = longint'(1) << (2 * FRAC_BITS);
   localparam int SH_R = (2 * FRAC_BITS >= WB) ? 2 * FRAC_BITS - WB : 0;
   localparam int SH_L = (2 * FRAC_BITS >= WB) ? 0 : WB - 2 * FRAC_BITS;
   localparam logic signed [57:0] RND = 58'sd1 <<< (WB - 1);
   localparam logic [60:0] ONE_SQ = 61'(1) << (2 * WB);

   logic             en;
   logic [P_OUT:1]   vld_ff;

   assign en = !vld_ff[P_OUT] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[P_OUT];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[P_OUT-1:1], req_valid};
      end
   end

   // stage 1: input beat
   qslerp_pkg::req_type req1_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         req1_ff <= req_data;
      end
   end

   // stage 2: products and blend decode
   qslerp_pkg::req_type  req2_ff;
   qslerp_pkg::sel_type  sel2_ff;
   qslerp_pkg::sel_type  sel_in;
   logic signed [31:0]   prod_ff [4];

   always_comb begin
      if (longint'(req1_ff.blend) > HI_LIM) begin
         sel_in = qslerp_pkg::SEL_DST;
      end else if (longint'(req1_ff.blend) < LO_LIM) begin
         sel_in = qslerp_pkg::SEL_SRC;
      end else begin
         sel_in = qslerp_pkg::SEL_MIX;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         req2_ff    <= req1_ff;
         sel2_ff    <= sel_in;
         prod_ff[0] <= req1_ff.src_w * req1_ff.dst_w;
         prod_ff[1] <= req1_ff.src_x * req1_ff.dst_x;
         prod_ff[2] <= req1_ff.src_y * req1_ff.dst_y;
         prod_ff[3] <= req1_ff.src_z * req1_ff.dst_z;
      end
   end

   // stage 3: dot sum
   qslerp_pkg::req_type  req3_ff;
   qslerp_pkg::sel_type  sel3_ff;
   logic signed [33:0]   dot_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         req3_ff <= req2_ff;
         sel3_ff <= sel2_ff;
         dot_ff  <= 34'(prod_ff[0]) + 34'(prod_ff[1]) + 34'(prod_ff[2]) + 34'(prod_ff[3]);
      end
   end

   // stage 4: sign fold, clamp, cosine to Q30
   logic               neg;
   logic signed [33:0] dabs;
   logic [63:0]        dcl;
   logic [63:0]        dsh;
   logic [3:0][16:0]   sp_in;
   logic [3:0][15:0]   dq_in;
   logic [3:0][16:0]   sp4_ff;
   logic [3:0][15:0]   dq4_ff;
   logic [WB-1:0]      t30_4_ff;
   logic [WB:0]        c30_4_ff;
   qslerp_pkg::sel_type sel4_ff;

   always_comb begin
      neg  = (dot_ff < 0) && (sel3_ff == qslerp_pkg::SEL_MIX);
      dabs = neg ? -dot_ff : dot_ff;
      dcl  = 64'(dabs[32:0]);
      if (dcl > 64'(DOT_LIM)) begin
         dcl = 64'(DOT_LIM);
      end
      dsh = (2 * FRAC_BITS >= WB) ? (dcl >> SH_R) : (dcl << SH_L);
      sp_in[0] = neg ? -17'(req3_ff.src_w) : 17'(req3_ff.src_w);
      sp_in[1] = neg ? -17'(req3_ff.src_x) : 17'(req3_ff.src_x);
      sp_in[2] = neg ? -17'(req3_ff.src_y) : 17'(req3_ff.src_y);
      sp_in[3] = neg ? -17'(req3_ff.src_z) : 17'(req3_ff.src_z);
      dq_in[0] = req3_ff.dst_w;
      dq_in[1] = req3_ff.dst_x;
      dq_in[2] = req3_ff.dst_y;
      dq_in[3] = req3_ff.dst_z;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sp4_ff   <= sp_in;
         dq4_ff   <= dq_in;
         c30_4_ff <= dsh[WB:0];
         t30_4_ff <= WB'(req3_ff.blend[14:0]) << (WB - FRAC_BITS);
         sel4_ff  <= sel3_ff;
      end
   end

   // stage 5 on: side data line, squared cosine, radicand
   qslerp_pkg::side_type side_in;
   qslerp_pkg::side_type side_ff [SIDE_N];
   logic [60:0]          sq_ff;
   logic [60:0]          rad_ff;

   always_comb begin
      side_in.sp  = sp4_ff;
      side_in.dq  = dq4_ff;
      side_in.t30 = t30_4_ff;
      side_in.c30 = c30_4_ff;
      side_in.sel = sel4_ff;
      side_in.np  = longint'(c30_4_ff) > qslerp_pkg::NP_LIM;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int j = 1; j < SIDE_N; j++) begin
            side_ff[j] <= side_ff[j-1];
         end
         sq_ff  <= 61'(62'(c30_4_ff) * 62'(c30_4_ff));
         rad_ff <= ONE_SQ - sq_ff;
      end
   end

   // integer square root, one root bit per stage
   logic [33:0] srem_ff [SQ_N];
   logic [30:0] sq_q_ff [SQ_N];
   logic [61:0] srad_ff [SQ_N];

   genvar gi;
   for (gi = 0; gi < SQ_N; gi++) begin : g_sqrt
      localparam int B = SQ_N - 1 - gi;
      logic [33:0] ri;
      logic [30:0] qi;
      logic [61:0] di;
      logic [33:0] cur;
      logic [33:0] trial;
      if (gi == 0) begin : g_first
         assign ri = '0;
         assign qi = '0;
         assign di = {1'b0, rad_ff};
      end else begin : g_next
         assign ri = srem_ff[gi-1];
         assign qi = sq_q_ff[gi-1];
         assign di = srad_ff[gi-1];
      end
      assign cur = {ri[31:0], di[2*B+1 -: 2]};
      assign trial = {1'b0, qi, 2'b01};
      always_ff @(posedge clock) begin
         if (en) begin
            if (cur >= trial) begin
               srem_ff[gi] <= cur - trial;
               sq_q_ff[gi] <= {qi[29:0], 1'b1};
            end else begin
               srem_ff[gi] <= cur;
               sq_q_ff[gi] <= {qi[29:0], 1'b0};
            end
            srad_ff[gi] <= di;
         end
      end
   end

   logic [30:0] sn;
   assign sn = sq_q_ff[SQ_N-1];

   // vectoring CORDIC: omega = atan2(sine, cosine)
   logic signed [33:0] vx_ff [CS];
   logic signed [33:0] vy_ff [CS];
   logic signed [32:0] vz_ff [CS];

   for (gi = 0; gi < CS; gi++) begin : g_vec
      logic signed [33:0] xi;
      logic signed [33:0] yi;
      logic signed [32:0] zi;
      logic signed [32:0] at;
      if (gi == 0) begin : g_first
         assign xi = $signed({3'b000, side_ff[P_SN-5].c30});
         assign yi = $signed({3'b000, sn});
         assign zi = '0;
      end else begin : g_next
         assign xi = vx_ff[gi-1];
         assign yi = vy_ff[gi-1];
         assign zi = vz_ff[gi-1];
      end
      assign at = $signed({2'b00, qslerp_pkg::ATAN_TAB[gi]});
      always_ff @(posedge clock) begin
         if (en) begin
            if (yi >= 0) begin
               vx_ff[gi] <= xi + (yi >>> gi);
               vy_ff[gi] <= yi - (xi >>> gi);
               vz_ff[gi] <= zi + at;
            end else begin
               vx_ff[gi] <= xi - (yi >>> gi);
               vy_ff[gi] <= yi + (xi >>> gi);
               vz_ff[gi] <= zi - at;
            end
         end
      end
   end

   // angle split
   logic [30:0] om;
   logic [WB:0] w0;
   logic [61:0] a0p;
   logic [61:0] a1p;
   logic [30:0] a0_ff;
   logic [30:0] a1_ff;

   always_comb begin
      om  = vz_ff[CS-1][32] ? '0 : vz_ff[CS-1][30:0];
      w0  = qslerp_pkg::ONE_W - {1'b0, side_ff[P_OM-5].t30};
      a0p = 62'(w0) * 62'(om);
      a1p = 62'(side_ff[P_OM-5].t30) * 62'(om);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a0_ff <= a0p[60:30];
         a1_ff <= a1p[60:30];
      end
   end

   logic signed [33:0] sin0;
   logic signed [33:0] sin1;

   qslerp_rot #(.STAGES(CS)) u_rot0 (
      .clock   (clock),
      .en      (en),
      .ang     (a0_ff),
      .sin_out (sin0)
   );

   qslerp_rot #(.STAGES(CS)) u_rot1 (
      .clock   (clock),
      .en      (en),
      .ang     (a1_ff),
      .sin_out (sin1)
   );

   logic [30:0] sn_dl_ff [SN_N];
   always_ff @(posedge clock) begin
      if (en) begin
         sn_dl_ff[0] <= sn;
         for (int j = 1; j < SN_N; j++) begin
            sn_dl_ff[j] <= sn_dl_ff[j-1];
         end
      end
   end

   logic signed [39:0] k0d;
   logic signed [39:0] k1d;

   qslerp_div u_div0 (
      .clock (clock),
      .en    (en),
      .num   (sin0),
      .den   (sn_dl_ff[SN_N-1]),
      .quo   (k0d)
   );

   qslerp_div u_div1 (
      .clock (clock),
      .en    (en),
      .num   (sin1),
      .den   (sn_dl_ff[SN_N-1]),
      .quo   (k1d)
   );

   // weight products
   qslerp_pkg::side_type sk;
   logic signed [39:0]   k0;
   logic signed [39:0]   k1;
   logic signed [56:0]   pm_ff [4];
   logic signed [55:0]   dm_ff [4];
   logic [3:0][15:0]     srcm_ff;
   logic [3:0][15:0]     dstm_ff;
   qslerp_pkg::sel_type  selm_ff;

   always_comb begin
      sk = side_ff[SIDE_N-1];
      k0 = sk.np ? $signed(40'(qslerp_pkg::ONE_W - {1'b0, sk.t30})) : k0d;
      k1 = sk.np ? $signed(40'(sk.t30)) : k1d;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 4; j++) begin
            pm_ff[j]   <= $signed(sk.sp[j]) * k0;
            dm_ff[j]   <= $signed(sk.dq[j]) * k1;
            srcm_ff[j] <= sk.sp[j][15:0];
            dstm_ff[j] <= sk.dq[j];
         end
         selm_ff <= sk.sel;
      end
   end

   // round, saturate, select
   logic [3:0][15:0]   mix;
   logic signed [57:0] acc [4];
   qslerp_pkg::rsp_type rsp_in;
   qslerp_pkg::rsp_type rsp_ff;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         acc[j] = 58'(pm_ff[j]) + 58'(dm_ff[j]) + RND;
         case (selm_ff)
            qslerp_pkg::SEL_SRC: mix[j] = srcm_ff[j];
            qslerp_pkg::SEL_DST: mix[j] = dstm_ff[j];
            default:             mix[j] = qslerp_pkg::sat16(acc[j][57:WB]);
         endcase
      end
      rsp_in.res_w = mix[0];
      rsp_in.res_x = mix[1];
      rsp_in.res_y = mix[2];
      rsp_in.res_z = mix[3];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/core/qslerp_rot.sv =====
// Pipelined rotation CORDIC returning the sine of a Q30 angle.
module qslerp_rot #(
   parameter int STAGES = 16
) (
   input  logic               clock,
   input  logic               en,
   input  logic [30:0]        ang,
   output logic signed [33:0] sin_out
);

   logic signed [33:0] x_ff [STAGES];
   logic signed [33:0] y_ff [STAGES];
   logic signed [32:0] z_ff [STAGES];

   genvar gi;
   for (gi = 0; gi < STAGES; gi++) begin : g_stage
      logic signed [33:0] xi;
      logic signed [33:0] yi;
      logic signed [32:0] zi;
      logic signed [32:0] at;
      if (gi == 0) begin : g_first
         assign xi = qslerp_pkg::INV_GAIN;
         assign yi = '0;
         assign zi = $signed({2'b00, ang});
      end else begin : g_next
         assign xi = x_ff[gi-1];
         assign yi = y_ff[gi-1];
         assign zi = z_ff[gi-1];
      end
      assign at = $signed({2'b00, qslerp_pkg::ATAN_TAB[gi]});
      always_ff @(posedge clock) begin
         if (en) begin
            if (zi >= 0) begin
               x_ff[gi] <= xi - (yi >>> gi);
               y_ff[gi] <= yi + (xi >>> gi);
               z_ff[gi] <= zi - at;
            end else begin
               x_ff[gi] <= xi + (yi >>> gi);
               y_ff[gi] <= yi - (xi >>> gi);
               z_ff[gi] <= zi + at;
            end
         end
      end
   end

   assign sin_out = y_ff[STAGES-1];

endmodule

// ===== rtl/core/qslerp_div.sv =====
// Pipelined restoring divider: (num * 2^30) / den, truncated toward zero.
module qslerp_div (
   input  logic               clock,
   input  logic               en,
   input  logic signed [33:0] num,
   input  logic [30:0]        den,
   output logic signed [39:0] quo
);

   localparam int QB = qslerp_pkg::QB;
   localparam int WB = qslerp_pkg::WB;
   localparam int PS = QB - WB;

   logic signed [33:0] mag;
   logic               neg0_ff;
   logic [30:0]        rem0_ff;
   logic [QB-1:0]      low0_ff;
   logic [30:0]        den0_ff;

   logic [30:0]    rem_ff [QB];
   logic [QB-1:0]  low_ff [QB];
   logic [QB-1:0]  q_ff   [QB];
   logic [30:0]    den_ff [QB];
   logic           neg_ff [QB];
   logic signed [39:0] quo_ff;

   assign mag = (num < 0) ? -num : num;

   always_ff @(posedge clock) begin
      if (en) begin
         neg0_ff <= num < 0;
         rem0_ff <= 31'(mag[30:PS]);
         low0_ff <= {mag[PS-1:0], {WB{1'b0}}};
         den0_ff <= den;
      end
   end

   genvar gi;
   for (gi = 0; gi < QB; gi++) begin : g_step
      logic [30:0]   ri;
      logic [QB-1:0] li;
      logic [QB-1:0] qi;
      logic [30:0]   di;
      logic          ni;
      logic [31:0]   cur;
      if (gi == 0) begin : g_first
         assign ri = rem0_ff;
         assign li = low0_ff;
         assign qi = '0;
         assign di = den0_ff;
         assign ni = neg0_ff;
      end else begin : g_next
         assign ri = rem_ff[gi-1];
         assign li = low_ff[gi-1];
         assign qi = q_ff[gi-1];
         assign di = den_ff[gi-1];
         assign ni = neg_ff[gi-1];
      end
      assign cur = {ri, li[QB-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            if (cur >= {1'b0, di}) begin
               rem_ff[gi] <= 31'(cur - {1'b0, di});
               q_ff[gi]   <= {qi[QB-2:0], 1'b1};
            end else begin
               rem_ff[gi] <= cur[30:0];
               q_ff[gi]   <= {qi[QB-2:0], 1'b0};
            end
            low_ff[gi] <= li << 1;
            den_ff[gi] <= di;
            neg_ff[gi] <= ni;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= neg_ff[QB-1] ? -$signed({1'b0, q_ff[QB-1]}) : $signed({1'b0, q_ff[QB-1]});
      end
   end

   assign quo = quo_ff;

endmodule
